### hdl/ida_pkg.sv
// ida_pkg: shared constants and types for the id allocator
// used by id_allocator_with_free_stack; no dependencies
`timescale 1ns / 1ps

package ida_pkg;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned STATUS_W = 2;

  // id step must be a power of two, alignment is checked with a mask
  localparam int unsigned ID_STEP  = 4;
  localparam int unsigned FIRST_ID = 4;

  localparam int unsigned POOL_DEPTH_DEF = 1024;

  localparam logic [ID_W-1:0] ID_ALIGN_MASK = ID_W'(ID_STEP - 1);

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_DROPPED   = 2'd2
  } status_e;

endpackage

### hdl/ida_ram.sv
// ida_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ida_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### hdl/id_allocator_with_free_stack.sv
// id_allocator_with_free_stack: id allocator with a lifo pool of released ids
// depends on ida_pkg and ida_ram
`timescale 1ns / 1ps
//
// Usage:
//   The input channel (in_valid_i / in_stall_o) takes one request word:
//   opcode_i selects allocate or release, freed_id_i is the id handed back
//   on release. Each request gives exactly one result word on the output
//   channel (out_valid_o / out_stall_i): granted_id_o and status_o.
//   For a release or a fresh-id allocate the result sits in the output
//   register at the edge after acceptance, and a new request can be taken
//   every cycle while no result is held under out_stall_i and no pool read
//   is pending. A pool allocate reads the pool ram (registered read) into
//   the output register; the input stalls while that read is pending.
//   While a result waits in the output register under out_stall_i, the
//   input stalls; it is taken again in the same cycle the result leaves.
//   Reset empties the pool, restarts fresh ids at the first id and clears
//   the exhausted flag. Pool contents need no clearing: a pop only reads
//   entries written by an earlier release.
//
module id_allocator_with_free_stack #(
  parameter int unsigned POOL_DEPTH = ida_pkg::POOL_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         opcode_i,
  input  logic [ida_pkg::ID_W-1:0]     freed_id_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ida_pkg::ID_W-1:0]     granted_id_o,
  output logic [ida_pkg::STATUS_W-1:0] status_o
);

  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned W  = ida_pkg::ID_W;

  logic [CW-1:0] count_q, count_d;
  logic [W-1:0]  fresh_q, fresh_d;
  logic          exh_q, exh_d;
  logic          pop_pend_q, pop_pend_d;
  logic          out_valid_q, out_valid_d;
  logic [W-1:0]  granted_q, granted_d;
  ida_pkg::status_e status_q, status_d;

  logic          accept;
  logic          we;
  logic [AW-1:0] raddr;
  logic [W-1:0]  rdata;
  logic [W:0]    fresh_sum;
  logic          release_ok;

  assign in_stall_o = pop_pend_q | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;

  assign fresh_sum  = {1'b0, fresh_q} + (W + 1)'(ida_pkg::ID_STEP);
  assign release_ok = (freed_id_i != '0)
                    && ((freed_id_i & ida_pkg::ID_ALIGN_MASK) == '0)
                    && (count_q < CW'(POOL_DEPTH));
  assign raddr      = AW'(count_q - CW'(1));
  assign we         = accept && (opcode_i == ida_pkg::OP_RELEASE) && release_ok;

  ida_ram #(
    .WIDTH (W),
    .DEPTH (POOL_DEPTH)
  ) u_pool (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (freed_id_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d     = count_q;
    fresh_d     = fresh_q;
    exh_d       = exh_q;
    pop_pend_d  = 1'b0;
    out_valid_d = out_valid_q & out_stall_i;
    granted_d   = granted_q;
    status_d    = status_q;

    if (pop_pend_q) begin
      // pool read data arrives in the cycle after the pop
      out_valid_d = 1'b1;
      granted_d   = rdata;
      status_d    = ida_pkg::ST_OK;
    end else if (accept) begin
      if (opcode_i == ida_pkg::OP_RELEASE) begin
        out_valid_d = 1'b1;
        granted_d   = '0;
        if (release_ok) begin
          count_d  = count_q + CW'(1);
          status_d = ida_pkg::ST_OK;
        end else begin
          status_d = ida_pkg::ST_DROPPED;
        end
      end else if (count_q != '0) begin
        count_d    = count_q - CW'(1);
        pop_pend_d = 1'b1;
      end else begin
        out_valid_d = 1'b1;
        if (exh_q || fresh_sum[W]) begin
          exh_d     = 1'b1;
          granted_d = '0;
          status_d  = ida_pkg::ST_EXHAUSTED;
        end else begin
          granted_d = fresh_q;
          fresh_d   = fresh_sum[W-1:0];
          status_d  = ida_pkg::ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      fresh_q     <= W'(ida_pkg::FIRST_ID);
      exh_q       <= 1'b0;
      pop_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      fresh_q     <= fresh_d;
      exh_q       <= exh_d;
      pop_pend_q  <= pop_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    granted_q <= granted_d;
    status_q  <= status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign granted_id_o = granted_q;
  assign status_o     = status_q;

  // output register is always free when the pool read data lands
  a_pend_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_pend_q |-> !out_valid_q)
    else $error("pool read completes while output register is occupied");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(POOL_DEPTH))
    else $error("pool count beyond depth");

  a_exh_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exh_q |=> exh_q)
    else $error("exhausted flag cleared");

  a_fresh_only_on_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && opcode_i == ida_pkg::OP_ALLOC) |=> $stable(fresh_q))
    else $error("fresh id counter moved without an allocate");

  a_grant_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && granted_q != '0) |-> status_q == ida_pkg::ST_OK)
    else $error("nonzero id delivered with a failure status");

endmodule

### tb/sv/tb_id_allocator_with_free_stack.sv
`timescale 1ns / 1ps
// tb_id_allocator_with_free_stack: self-checking bench for the lifo id allocator
// sends allocate and release words, predicts each grant and compares it field by field
// depends on ida_pkg and id_allocator_with_free_stack

module tb_id_allocator_with_free_stack;

  localparam int unsigned POOL_DEPTH  = ida_pkg::POOL_DEPTH_DEF;
  localparam int unsigned QUIET_LIMIT = 1000;

  typedef struct packed {
    logic [ida_pkg::ID_W-1:0] id;
    ida_pkg::status_e         status;
  } grant_t;

  typedef enum {ID_ZERO, ID_MISALIGNED, ID_SMALL, ID_WIDE} id_kind_e;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic                         opcode_i = ida_pkg::OP_ALLOC;
  logic [ida_pkg::ID_W-1:0]     freed_id_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [ida_pkg::ID_W-1:0]     granted_id_o;
  logic [ida_pkg::STATUS_W-1:0] status_o;

  // allocator state as the bench sees it
  logic [ida_pkg::ID_W-1:0] fresh_id;
  logic [ida_pkg::ID_W-1:0] free_stack[$];
  logic                     ids_exhausted;

  grant_t pending_grants[$];
  bit     idle_en = 1'b1;
  int     fail_cnt = 0;
  int     quiet_cycles = 0;
  int     stall_left = 0;

  id_allocator_with_free_stack #(.POOL_DEPTH(POOL_DEPTH)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .freed_id_i  (freed_id_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .granted_id_o(granted_id_o),
    .status_o    (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic grant_t predict_grant(logic op, logic [ida_pkg::ID_W-1:0] id);
    grant_t                 g;
    logic [ida_pkg::ID_W:0] wide_next;
    g.id     = '0;
    g.status = ida_pkg::ST_OK;
    if (op == ida_pkg::OP_RELEASE) begin
      if (id == '0 || id % ida_pkg::ID_STEP != 0 || free_stack.size() >= POOL_DEPTH)
        g.status = ida_pkg::ST_DROPPED;
      else
        free_stack.push_back(id);
    end else if (free_stack.size() > 0) begin
      g.id = free_stack.pop_back();
    end else if (ids_exhausted) begin
      g.status = ida_pkg::ST_EXHAUSTED;
    end else begin
      // carry out of the counter means the fresh id range is used up for good
      wide_next = {1'b0, fresh_id} + ida_pkg::ID_STEP;
      if (wide_next[ida_pkg::ID_W]) begin
        ids_exhausted = 1'b1;
        g.status      = ida_pkg::ST_EXHAUSTED;
      end else begin
        g.id     = fresh_id;
        fresh_id = wide_next[ida_pkg::ID_W-1:0];
      end
    end
    return g;
  endfunction

  function automatic logic [ida_pkg::ID_W-1:0] make_id(id_kind_e kind);
    logic [ida_pkg::ID_W-1:0] r;
    r = $urandom();
    if (kind == ID_SMALL) r = r % 32'h1000;
    r = r - r % ida_pkg::ID_STEP;
    if (kind == ID_MISALIGNED) r = r + $urandom_range(1, ida_pkg::ID_STEP - 1);
    else if (kind == ID_ZERO) r = '0;
    else if (r == '0) r = ida_pkg::ID_STEP;
    return r;
  endfunction

  function automatic logic [ida_pkg::ID_W-1:0] pick_release_id();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return make_id(ID_ZERO);
    if (roll < 3) return make_id(ID_MISALIGNED);
    if (roll < 6) return make_id(ID_SMALL);
    return make_id(ID_WIDE);
  endfunction

  task automatic issue_request(input logic op, input logic [ida_pkg::ID_W-1:0] id);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    freed_id_i <= id;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_grants.push_back(predict_grant(op, id));
  endtask

  task automatic drain_grants();
    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_basic_requests();
    issue_request(ida_pkg::OP_ALLOC, '1);
    issue_request(ida_pkg::OP_ALLOC, '0);
    issue_request(ida_pkg::OP_RELEASE, ida_pkg::ID_W'(ida_pkg::FIRST_ID));
    issue_request(ida_pkg::OP_ALLOC, $urandom());
    issue_request(ida_pkg::OP_ALLOC, $urandom());
    issue_request(ida_pkg::OP_RELEASE, '0);
    issue_request(ida_pkg::OP_RELEASE, 32'h0000_0001);
    issue_request(ida_pkg::OP_RELEASE, 32'h0000_0002);
    issue_request(ida_pkg::OP_RELEASE, 32'h0000_0003);
    issue_request(ida_pkg::OP_RELEASE, 32'hffff_ffff);
    issue_request(ida_pkg::OP_RELEASE, 32'hffff_fffc);
    issue_request(ida_pkg::OP_RELEASE, 32'h8000_0000);
    issue_request(ida_pkg::OP_RELEASE, 32'h7fff_fffd);
    // never issued, then handed back twice
    issue_request(ida_pkg::OP_RELEASE, 32'h0000_03e8);
    issue_request(ida_pkg::OP_RELEASE, 32'h0000_03e8);
    repeat (5) issue_request(ida_pkg::OP_ALLOC, $urandom());
    issue_request(ida_pkg::OP_RELEASE, 32'h5555_5554);
    issue_request(ida_pkg::OP_RELEASE, 32'haaaa_aaa8);
    repeat (3) issue_request(ida_pkg::OP_ALLOC, $urandom());
    drain_grants();
  endtask

  task automatic test_random_traffic(input int n);
    int rel_pct;
    rel_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       rel_pct = 30;
          1:       rel_pct = 50;
          default: rel_pct = 80;
        endcase
        idle_en = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 99) < rel_pct)
        issue_request(ida_pkg::OP_RELEASE, pick_release_id());
      else
        issue_request(ida_pkg::OP_ALLOC, $urandom());
    end
    idle_en = 1'b1;
    drain_grants();
  endtask

  task automatic test_pool_full();
    while (free_stack.size() < POOL_DEPTH)
      issue_request(ida_pkg::OP_RELEASE, pick_release_id());
    // pool is full: aligned ids get dropped too
    repeat (3) issue_request(ida_pkg::OP_RELEASE, make_id(ID_WIDE));
    issue_request(ida_pkg::OP_RELEASE, make_id(ID_ZERO));
    issue_request(ida_pkg::OP_RELEASE, make_id(ID_MISALIGNED));
    repeat (4) issue_request(ida_pkg::OP_ALLOC, $urandom());
    repeat (4) issue_request(ida_pkg::OP_RELEASE, make_id(ID_SMALL));
    repeat (3) issue_request(ida_pkg::OP_ALLOC, $urandom());
    drain_grants();
  endtask

  task automatic test_back_to_back(input int n);
    idle_en = 1'b0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0)
        issue_request(ida_pkg::OP_RELEASE, pick_release_id());
      else
        issue_request(ida_pkg::OP_ALLOC, $urandom());
    end
    drain_grants();
  endtask

  // out_stall_i is raised in bursts, each started at random while idle_en is set
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_grant
    grant_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_grants.size() == 0) begin
        $error("granted_id: unexpected word, actual %h status %0d", granted_id_o, status_o);
        fail_cnt++;
      end else begin
        want = pending_grants.pop_front();
        if (granted_id_o !== want.id) begin
          $error("granted_id mismatch: expected %h, actual %h", want.id, granted_id_o);
          fail_cnt++;
        end
        if (status_o !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else if (++quiet_cycles >= QUIET_LIMIT) begin
      $error("no word moved for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    fresh_id      = ida_pkg::ID_W'(ida_pkg::FIRST_ID);
    ids_exhausted = 1'b0;
    free_stack.delete();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_requests();
    test_random_traffic(200);
    test_pool_full();
    test_back_to_back(150);

    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0 && pending_grants.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
